// ----- src/interarrival_jitter_monitor_unit_macros.svh -----
// assertion macros shared by the interarrival jitter monitor rtl
`ifndef INTERARRIVAL_JITTER_MONITOR_UNIT_MACROS_SVH
`define INTERARRIVAL_JITTER_MONITOR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define JIM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("jim assertion failed");

// next-cycle implication, checked out of reset
`define JIM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("jim assertion failed");

`endif

// ----- src/jim_pkg.sv -----
// shared types and constants of the interarrival jitter monitor
`default_nettype none

package jim_pkg;

    localparam int TIME_W  = 48;
    localparam int DELTA_W = 32;
    localparam int MEAN_W  = 40;
    localparam int FRAC_W  = 8;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_CLEAR   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_MINMAX,
        ST_SUB,
        ST_ADD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ----- src/jim_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module jim_div
    import jim_pkg::*;
#(
    parameter int DVD_W = 49,
    parameter int DVS_W = 9
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_status_t           status,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CTR_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [CTR_W-1:0] ctr_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;

    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && ctr_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // quotient bits shift in from the bottom as the dividend shifts out
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            ctr_reg <= CTR_W'(DVD_W - 1);
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            ctr_reg <= ctr_reg - 1'b1;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = dvd_reg;

endmodule

`default_nettype wire

// ----- src/jim_ring.sv -----
// delta ring storage, one write port and one registered read port
`default_nettype none

module jim_ring
    import jim_pkg::*;
#(
    parameter int DEPTH  = 500,
    parameter int ADDR_W = 9
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [DELTA_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output logic      [DELTA_W-1:0] rd_data
);

    logic [DELTA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/interarrival_jitter_monitor_unit.sv -----
// top level of the interarrival jitter monitor: sequencer, statistics and ring
//
//  channel | direction | ports                                    | handshake
//  --------+-----------+------------------------------------------+----------------
//  s_      | in        | s_func, s_arrival_time                   | s_valid/s_ready
//  m_      | out       | m_min_delta, m_max_delta, m_avg_delta,   | m_valid/m_ready
//          |           | m_stats_valid                            |
//
// an arrival with a delta steps through the delta, min/max, subtract and add states,
// then the serial divider forms the window mean, one quotient bit a cycle
// a clear or first arrival goes straight to the divider, which is skipped when no delta exists yet
// one word in flight: s_ready is high only while the sequencer is idle
// a finished word sits in the output register; the next word may be taken meanwhile
// synchronous active-low reset clears statistics, ring pointer, count and sum
`default_nettype none

`include "interarrival_jitter_monitor_unit_macros.svh"

module interarrival_jitter_monitor_unit
    import jim_pkg::*;
#(
    parameter int WINDOW_LEN = 500
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_func,
    input  wire logic [TIME_W-1:0] s_arrival_time,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DELTA_W-1:0]     m_min_delta,
    output logic [DELTA_W-1:0]     m_max_delta,
    output logic [MEAN_W-1:0]      m_avg_delta,
    output logic                   m_stats_valid
);

    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = DELTA_W + CNT_W;
    localparam int DVD_W = SUM_W + FRAC_W;

    state_t state_reg;
    state_t state_next;

    logic [TIME_W-1:0]  time_in_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic               seen_first_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [DELTA_W-1:0] min_reg;
    logic [DELTA_W-1:0] max_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [MEAN_W-1:0]  mean_reg;

    logic               m_valid_reg;
    logic [DELTA_W-1:0] m_min_reg;
    logic [DELTA_W-1:0] m_max_reg;
    logic [MEAN_W-1:0]  m_mean_reg;
    logic               m_stats_reg;

    logic               accept;
    logic               out_free;
    logic               ring_full;
    logic [TIME_W-1:0]  raw_delta;
    logic               div_start;
    logic               rd_en;
    logic               wr_en;
    logic [DELTA_W-1:0] rd_data;
    logic [DVD_W-1:0]   quotient;
    div_status_t        div_status;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign ring_full = count_reg == CNT_W'(WINDOW_LEN);
    assign raw_delta = time_in_reg - last_time_reg;

    jim_ring #(
        .DEPTH  (WINDOW_LEN),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (delta_reg),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    jim_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({sum_reg, {FRAC_W{1'b0}}}),
        .divisor  (count_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_ARRIVAL && seen_first_reg) begin
                        state_next = ST_DELTA;
                    end else begin
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_DELTA:  state_next = ST_MINMAX;
            ST_MINMAX: begin
                rd_en      = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:    state_next = ST_ADD;
            ST_ADD: begin
                wr_en      = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                if (count_reg != '0) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV_WAIT: begin
                if (div_status.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // statistics state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg  <= '0;
            seen_first_reg <= 1'b0;
            min_reg        <= '1;
            max_reg        <= '0;
            ptr_reg        <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_func == FUNC_CLEAR) begin
                            min_reg <= '1;
                            max_reg <= '0;
                        end else if (!seen_first_reg) begin
                            last_time_reg  <= s_arrival_time;
                            seen_first_reg <= 1'b1;
                        end
                    end
                end
                ST_DELTA: begin
                    last_time_reg <= time_in_reg;
                end
                ST_MINMAX: begin
                    if (delta_reg > max_reg) begin
                        max_reg <= delta_reg;
                    end
                    if (delta_reg < min_reg) begin
                        min_reg <= delta_reg;
                    end
                end
                ST_SUB: begin
                    // oldest entry leaves the window once it is full
                    if (ring_full) begin
                        sum_reg <= sum_reg - SUM_W'(rd_data);
                    end
                end
                ST_ADD: begin
                    sum_reg <= sum_reg + SUM_W'(delta_reg);
                    ptr_reg <= (ptr_reg == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_reg + 1'b1;
                    if (!ring_full) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // word payload, delta and mean, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            time_in_reg <= s_arrival_time;
        end
        if (state_reg == ST_DELTA) begin
            delta_reg <= (raw_delta[TIME_W-1:DELTA_W] != '0) ? '1 : raw_delta[DELTA_W-1:0];
        end
        if (state_reg == ST_DIV_START) begin
            mean_reg <= '0;
        end else if (state_reg == ST_DIV_WAIT && div_status.done) begin
            mean_reg <= quotient[MEAN_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_min_reg   <= min_reg;
            m_max_reg   <= max_reg;
            m_mean_reg  <= mean_reg;
            m_stats_reg <= count_reg != '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_min_delta   = m_min_reg;
    assign m_max_delta   = m_max_reg;
    assign m_avg_delta   = m_mean_reg;
    assign m_stats_valid = m_stats_reg;

    `JIM_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(WINDOW_LEN))
    `JIM_ASSERT_IMPL(a_ptr_tracks_count, aclk, aresetn, !ring_full, ptr_reg == PTR_W'(count_reg))
    `JIM_ASSERT_IMPL(a_div_nonzero, aclk, aresetn, div_start, count_reg != '0)
    `JIM_ASSERT_NEXT(a_fin_loads, aclk, aresetn, state_reg == ST_FIN && out_free, m_valid)
    `JIM_ASSERT_IMPL(a_min_le_max, aclk, aresetn, max_reg != '0, min_reg <= max_reg)

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// testbench of the interarrival jitter monitor: directed and random words against a predictor
`timescale 1ns / 100ps

module tb;
    import jim_pkg::*;

    // window length of the default build
    localparam int WIN_LEN     = 500;
    localparam int RAND_WORDS  = 450;
    localparam int DIRECTED    = 17;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 120;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_SHOWN   = 10;
    localparam int EXP_DEPTH   = 1024;

    typedef struct packed {
        logic [DELTA_W-1:0] min_d;
        logic [DELTA_W-1:0] max_d;
        logic [MEAN_W-1:0]  mean;
        logic               valid;
    } stats_t;

    typedef struct {
        logic              func;
        logic [TIME_W-1:0] stamp;
        bit                typed;
        stats_t            want;
    } stim_row_t;

    localparam stats_t EMPTY_STATS = {32'hFFFF_FFFF, 32'h0, 40'h0, 1'b0};

    logic              aclk;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic              s_func         = FUNC_ARRIVAL;
    logic [TIME_W-1:0] s_arrival_time = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [DELTA_W-1:0] m_min_delta;
    logic [DELTA_W-1:0] m_max_delta;
    logic [MEAN_W-1:0]  m_avg_delta;
    logic               m_stats_valid;

    // typed expectation travels with the word, driven alongside the payload
    bit     use_typed   = 1'b0;
    stats_t typed_stats = EMPTY_STATS;

    // predictor state
    logic [TIME_W-1:0]  prev_stamp = '0;
    bit                 have_first = 1'b0;
    logic [DELTA_W-1:0] low_delta  = '1;
    logic [DELTA_W-1:0] high_delta = '0;
    logic [DELTA_W-1:0] delta_hist [WIN_LEN];
    int unsigned        hist_slot  = 0;
    int unsigned        hist_fill  = 0;
    logic [40:0]        window_total = '0;

    // expected words in order, written at input accept and read at output accept
    stats_t exp_fifo [EXP_DEPTH];
    int     exp_wr      = 0;
    int     exp_rd      = 0;
    int     bad_words   = 0;
    int     words_out   = 0;
    int     cycle_count = 0;

    interarrival_jitter_monitor_unit #(
        .WINDOW_LEN(WIN_LEN)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_arrival_time(s_arrival_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_min_delta   (m_min_delta),
        .m_max_delta   (m_max_delta),
        .m_avg_delta   (m_avg_delta),
        .m_stats_valid (m_stats_valid)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("interarrival_jitter_monitor_unit regression: fail");
            $finish;
        end
    end

    // advances the statistics by one word and returns what the block should report
    function automatic void advance_stats(input logic func, input logic [TIME_W-1:0] stamp,
                                          output stats_t calc);
        logic [TIME_W-1:0]  span_us;
        logic [DELTA_W-1:0] d;
        logic [63:0]        scaled;
        if (func == FUNC_CLEAR) begin
            low_delta  = '1;
            high_delta = '0;
        end else begin
            if (have_first) begin
                span_us = stamp - prev_stamp;
                d = (span_us > 48'hFFFF_FFFF) ? '1 : span_us[DELTA_W-1:0];
                if (d > high_delta) high_delta = d;
                if (d < low_delta) low_delta = d;
                // oldest entry leaves the sum once the window is full
                if (hist_fill >= WIN_LEN) window_total = window_total - delta_hist[hist_slot];
                else hist_fill++;
                delta_hist[hist_slot] = d;
                window_total = window_total + d;
                hist_slot = (hist_slot + 1 == WIN_LEN) ? 0 : hist_slot + 1;
            end
            prev_stamp = stamp;
            have_first = 1'b1;
        end
        scaled = {23'b0, window_total} << FRAC_W;
        calc.min_d = low_delta;
        calc.max_d = high_delta;
        calc.mean  = (hist_fill != 0) ? MEAN_W'(scaled / hist_fill) : '0;
        calc.valid = (hist_fill != 0);
    endfunction

    always @(posedge aclk) begin
        stats_t calc;
        if (aresetn && s_valid && s_ready) begin
            advance_stats(s_func, s_arrival_time, calc);
            exp_fifo[exp_wr % EXP_DEPTH] = use_typed ? typed_stats : calc;
            exp_wr++;
        end
    end

    always @(posedge aclk) begin
        stats_t got;
        stats_t want;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            got = {m_min_delta, m_max_delta, m_avg_delta, m_stats_valid};
            if (exp_wr == exp_rd) begin
                bad_words++;
                if (bad_words <= MAX_SHOWN)
                    $display("unexpected word: min %h max %h mean %h valid %b",
                             got.min_d, got.max_d, got.mean, got.valid);
            end else begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got.min_d !== want.min_d || got.max_d !== want.max_d ||
                    got.mean !== want.mean || got.valid !== want.valid) begin
                    bad_words++;
                    if (bad_words <= MAX_SHOWN)
                        $display("word %0d mismatch: exp min %h max %h mean %h valid %b, %s",
                                 words_out, want.min_d, want.max_d, want.mean, want.valid,
                                 $sformatf("got min %h max %h mean %h valid %b",
                                           got.min_d, got.max_d, got.mean, got.valid));
                end
            end
        end
    end

    // receiver: changing stall modes, plus one long hold-off to back the block up
    initial begin
        int mode;
        int span;
        int stall_left;
        bit held_off;
        stall_left = 0;
        held_off   = 1'b0;
        wait (aresetn);
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(16, 160);
            repeat (span) begin
                @(posedge aclk);
                if (!held_off && words_out >= 120) begin
                    held_off = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 2) != 0);
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            m_ready <= 1'b0;
                        end else if ($urandom_range(0, 7) == 0) begin
                            stall_left = $urandom_range(1, 24);
                            m_ready <= 1'b0;
                        end else begin
                            m_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // offers one word after an optional gap; drain waits for all results first
    task automatic send_word(input logic func, input logic [TIME_W-1:0] stamp,
                             input bit typed, input stats_t want, input int gap,
                             input bit drain);
        if (gap > 0 || drain) begin
            s_valid        <= 1'b0;
            s_func         <= 1'($urandom_range(0, 1));
            s_arrival_time <= TIME_W'({$urandom, $urandom});
            repeat ((gap > 0) ? gap : 1) @(posedge aclk);
            while (drain && exp_wr != exp_rd) @(posedge aclk);
        end
        s_func         <= func;
        s_arrival_time <= stamp;
        use_typed      <= typed;
        typed_stats    <= want;
        s_valid        <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        stim_row_t         script [DIRECTED];
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] stamp;
        logic              func;
        int                pick;
        int                gap;
        int                burst_left;
        bit                drain;

        script[0]  = '{FUNC_CLEAR,   48'h0, 1'b1, EMPTY_STATS};
        // first arrival only stores the timestamp
        script[1]  = '{FUNC_ARRIVAL, 48'h0, 1'b1, EMPTY_STATS};
        script[2]  = '{FUNC_ARRIVAL, 48'h0, 1'b1, {32'h0, 32'h0, 40'h0, 1'b1}};
        script[3]  = '{FUNC_ARRIVAL, 48'hFFFF_FFFF_FFFF, 1'b1,
                       {32'h0, 32'hFFFF_FFFF, 40'h7F_FFFF_FF80, 1'b1}};
        // time going backwards wraps
        script[4]  = '{FUNC_ARRIVAL, 48'h0, 1'b0, EMPTY_STATS};
        script[5]  = '{FUNC_CLEAR,   48'hFFFF_FFFF_FFFF, 1'b0, EMPTY_STATS};
        script[6]  = '{FUNC_ARRIVAL, 48'h1_0000_0000, 1'b0, EMPTY_STATS};
        script[7]  = '{FUNC_ARRIVAL, 48'h1_FFFF_FFFF, 1'b0, EMPTY_STATS};
        script[8]  = '{FUNC_ARRIVAL, 48'h2_0000_0000, 1'b0, EMPTY_STATS};
        script[9]  = '{FUNC_CLEAR,   48'h0, 1'b0, EMPTY_STATS};
        script[10] = '{FUNC_CLEAR,   48'h5555_5555_5555, 1'b0, EMPTY_STATS};
        script[11] = '{FUNC_ARRIVAL, 48'h8000_0000_0000, 1'b0, EMPTY_STATS};
        script[12] = '{FUNC_ARRIVAL, 48'h8000_0000_0000, 1'b0, EMPTY_STATS};
        script[13] = '{FUNC_ARRIVAL, 48'hAAAA_AAAA_AAAA, 1'b0, EMPTY_STATS};
        script[14] = '{FUNC_ARRIVAL, 48'h5555_5555_5555, 1'b0, EMPTY_STATS};
        script[15] = '{FUNC_ARRIVAL, 48'h5555_5555_593D, 1'b0, EMPTY_STATS};
        script[16] = '{FUNC_ARRIVAL, 48'h5555_5555_593E, 1'b0, EMPTY_STATS};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED; i++)
            send_word(script[i].func, script[i].stamp, script[i].typed, script[i].want,
                      $urandom_range(0, 3), 1'b0);

        now_us     = script[DIRECTED-1].stamp;
        burst_left = 0;
        for (int i = 0; i < RAND_WORDS; i++) begin
            pick = $urandom_range(0, 99);
            func = FUNC_ARRIVAL;
            if (pick < 8) begin
                func  = FUNC_CLEAR;
                stamp = TIME_W'({$urandom, $urandom});
            end else begin
                if (pick < 60)      step = TIME_W'($urandom_range(0, 2000));
                else if (pick < 70) step = '0;
                // around the 32-bit saturation point
                else if (pick < 80) step = 48'hFFFF_FFFE + TIME_W'($urandom_range(0, 3));
                else if (pick < 88) step = TIME_W'($urandom);
                else if (pick < 94) step = ~TIME_W'($urandom_range(0, 4999));
                else                step = TIME_W'({$urandom, $urandom});
                now_us = now_us + step;
                stamp  = now_us;
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                gap = 0;
            end
            burst_left--;
            drain = (i == 200) || ($urandom_range(0, 59) == 0);
            send_word(func, stamp, 1'b0, EMPTY_STATS, gap, drain);
        end
        s_valid <= 1'b0;

        while (exp_wr != exp_rd) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (bad_words == 0 && exp_wr == exp_rd) begin
            $display("interarrival_jitter_monitor_unit regression: pass");
        end else begin
            $display("interarrival_jitter_monitor_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/jim_pkg.sv
src/jim_div.sv
src/jim_ring.sv
src/interarrival_jitter_monitor_unit.sv
test/tb.sv
